/* design/seven_segment_frame_builder_macros.svh */
// seven_segment_frame_builder_macros.svh
// assertion macros for the seven-segment frame builder; no dependencies
// defining ASSERT_OFF removes every assertion body
`ifndef SEVEN_SEGMENT_FRAME_BUILDER_MACROS_SVH
`define SEVEN_SEGMENT_FRAME_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication under a clock and an active-low reset
`define SSFB_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("seven segment frame builder assertion failed");
// next-cycle implication under a clock and an active-low reset
`define SSFB_ASSERT_NXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("seven segment frame builder assertion failed");
`else
`define SSFB_ASSERT_IMP(label, clk, rstn, cond, prop)
`define SSFB_ASSERT_NXT(label, clk, rstn, cond, prop)
`endif

`endif

/* design/ssfb_pkg.sv */
// ssfb_pkg.sv
// command codes, font table and decimal helpers for the seven-segment frame builder
// no dependencies
`timescale 1ns / 1ps

package ssfb_pkg;

    // command codes
    typedef enum logic [1:0] {
        OP_SHOW   = 2'd0,
        OP_POINT  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_BRIGHT = 2'd3
    } op_t;

    localparam int unsigned NUM_W   = 14;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned DIGITS  = 4;
    localparam int unsigned POINT_BIT = 7;

    localparam logic [NUM_W-1:0] MAX_NUMBER = 14'd9999;
    localparam logic [NUM_W-1:0] MAX_LEVEL  = 14'd15;

    localparam logic [SEG_W-1:0] SEG_B = 8'h7C;
    localparam logic [SEG_W-1:0] SEG_R = 8'h50;

    // reciprocals of ten, a hundred and a thousand, exact for every 14-bit value
    localparam logic [12:0] RECIP_10 = 13'd6554;
    localparam int unsigned RECIP_SHIFT = 16;
    localparam logic [13:0] RECIP_100 = 14'd10486;
    localparam int unsigned RECIP_100_SHIFT = 20;
    localparam logic [14:0] RECIP_1000 = 15'd16778;
    localparam int unsigned RECIP_1000_SHIFT = 24;

    typedef logic [SEG_W-1:0] seg_t;

    // floor(n / 10) by multiply and shift
    function automatic logic [NUM_W-1:0] div10(input logic [NUM_W-1:0] n);
        logic [26:0] prod;
        prod = 27'(n) * 27'(RECIP_10);
        return NUM_W'(prod >> RECIP_SHIFT);
    endfunction

    // floor(n / 100) by multiply and shift
    function automatic logic [NUM_W-1:0] div100(input logic [NUM_W-1:0] n);
        logic [27:0] prod;
        prod = 28'(n) * 28'(RECIP_100);
        return NUM_W'(prod >> RECIP_100_SHIFT);
    endfunction

    // floor(n / 1000) by multiply and shift
    function automatic logic [NUM_W-1:0] div1000(input logic [NUM_W-1:0] n);
        logic [28:0] prod;
        prod = 29'(n) * 29'(RECIP_1000);
        return NUM_W'(prod >> RECIP_1000_SHIFT);
    endfunction

    // seven-segment font, digits 0..9 only, other codes blank
    function automatic seg_t font(input logic [3:0] d);
        seg_t s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

/* design/seven_segment_frame_builder.sv */
// seven_segment_frame_builder.sv
// frame builder for a four-digit seven-segment display with brightness level
// depends on ssfb_pkg and seven_segment_frame_builder_macros.svh
//
// usage
//   s_ channel: one command word per handshake (operation, number_in,
//   blank_zeros, digit_position, point_on); s_valid/s_ready.
//   m_ channel: one result word per command, the four segment bytes and the
//   brightness level after the command plus range_error; m_valid/m_ready.
//   a command is captured in an input register, decoded by the font and
//   decimal split logic (three reciprocal multiplications side by side) and
//   written to the frame registers, which drive the m_ ports directly.
//   path: a command moves from the input register into the frame registers,
//   and m_valid rises when the frame registers take it.
//   throughput: one command per cycle while m_ready is high.
//   stall: with m_ready low the result holds, one more command waits in the
//   input register, then s_ready drops until the result is taken.
//   reset: aresetn low clears the frame (blank display), the level and
//   both valid flags.
`timescale 1ns / 1ps
`include "seven_segment_frame_builder_macros.svh"

module seven_segment_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [13:0] s_number_in,
    input  logic        s_blank_zeros,
    input  logic [1:0]  s_digit_position,
    input  logic        s_point_on,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_seg_digit0,
    output logic [7:0]  m_seg_digit1,
    output logic [7:0]  m_seg_digit2,
    output logic [7:0]  m_seg_digit3,
    output logic [3:0]  m_level_out,
    output logic        m_range_error
);

    // input register
    logic                        in_valid_reg;
    logic [1:0]                  op_reg;
    logic [ssfb_pkg::NUM_W-1:0]  num_reg;
    logic                        omit_reg;
    logic [1:0]                  pos_reg;
    logic                        on_reg;

    // frame state, also the result register
    ssfb_pkg::seg_t              seg_reg  [ssfb_pkg::DIGITS];
    ssfb_pkg::seg_t              seg_next [ssfb_pkg::DIGITS];
    logic [ssfb_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                        err_reg, err_next;
    logic                        out_valid_reg;

    logic advance;

    // decimal split
    logic [ssfb_pkg::NUM_W-1:0] q1, q2, q3;
    logic [3:0] d0, d1, d2, d3;
    logic       omit, sh0, sh1, sh2;
    ssfb_pkg::seg_t f0, f1, f2, f3;
    ssfb_pkg::op_t op;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // capture the command word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            num_reg  <= s_number_in;
            omit_reg <= s_blank_zeros;
            pos_reg  <= s_digit_position;
            on_reg   <= s_point_on;
        end
    end

    // digits from three independent divides by constants
    always_comb begin
        q1 = ssfb_pkg::div10(num_reg);
        q2 = ssfb_pkg::div100(num_reg);
        q3 = ssfb_pkg::div1000(num_reg);
        d3 = 4'(num_reg - q1 * 14'd10);
        d2 = 4'(q1 - q2 * 14'd10);
        d1 = 4'(q2 - q3 * 14'd10);
        d0 = q3[3:0];
    end

    // font lookup with leading-zero blanking
    always_comb begin
        op   = ssfb_pkg::op_t'(op_reg);
        omit = (op == ssfb_pkg::OP_BRIGHT) ? 1'b1 : omit_reg;
        sh0  = !omit || (d0 != 4'd0);
        sh1  = sh0 || (d1 != 4'd0);
        sh2  = sh1 || (d2 != 4'd0);
        f0   = sh0 ? ssfb_pkg::font(d0) : '0;
        f1   = sh1 ? ssfb_pkg::font(d1) : '0;
        f2   = sh2 ? ssfb_pkg::font(d2) : '0;
        f3   = ssfb_pkg::font(d3);
    end

    // command execution
    always_comb begin
        seg_next   = seg_reg;
        level_next = level_reg;
        err_next   = 1'b0;
        case (op)
            ssfb_pkg::OP_SHOW: begin
                if (num_reg > ssfb_pkg::MAX_NUMBER) begin
                    err_next = 1'b1;
                end else begin
                    seg_next[0] = f0;
                    seg_next[1] = f1;
                    seg_next[2] = f2;
                    seg_next[3] = f3;
                end
            end
            ssfb_pkg::OP_POINT: begin
                seg_next[pos_reg][ssfb_pkg::POINT_BIT] = on_reg;
            end
            ssfb_pkg::OP_CLEAR: begin
                for (int i = 0; i < ssfb_pkg::DIGITS; i++) begin
                    seg_next[i] = '0;
                end
            end
            ssfb_pkg::OP_BRIGHT: begin
                if (num_reg > ssfb_pkg::MAX_LEVEL) begin
                    err_next = 1'b1;
                end else begin
                    level_next  = num_reg[ssfb_pkg::LEVEL_W-1:0];
                    seg_next[0] = ssfb_pkg::SEG_B;
                    seg_next[1] = ssfb_pkg::SEG_R;
                    seg_next[2] = f2;
                    seg_next[3] = f3;
                end
            end
            default: begin
                err_next = 1'b0;
            end
        endcase
    end

    // frame state and result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ssfb_pkg::DIGITS; i++) begin
                seg_reg[i] <= '0;
            end
            level_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                seg_reg       <= seg_next;
                level_reg     <= level_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_seg_digit0  = seg_reg[0];
    assign m_seg_digit1  = seg_reg[1];
    assign m_seg_digit2  = seg_reg[2];
    assign m_seg_digit3  = seg_reg[3];
    assign m_level_out   = level_reg;
    assign m_range_error = err_reg;

    // a rejected command leaves frame and level alone
    `SSFB_ASSERT_NXT(a_err_keeps_state, aclk, aresetn, advance && err_next, $stable(level_reg) && $stable(seg_reg[0]) && $stable(seg_reg[3]))
    // every executed command produces a result word
    `SSFB_ASSERT_NXT(a_advance_gives_result, aclk, aresetn, advance, out_valid_reg)
    // a waiting command is neither lost nor altered
    `SSFB_ASSERT_NXT(a_pending_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(op_reg) && $stable(num_reg))
    // frame only moves when the previous result has been taken
    `SSFB_ASSERT_IMP(a_no_overwrite, aclk, aresetn, advance && out_valid_reg, m_ready)

endmodule

/* sim/seven_segment_frame_builder_tb.sv */
// seven_segment_frame_builder_tb.sv
// self-checking testbench: directed and random commands, frames predicted in-bench
// depends on ssfb_pkg and the seven_segment_frame_builder rtl
`timescale 1ns / 1ps

module seven_segment_frame_builder_tb;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_OFF = 80;

    localparam logic [7:0] DIGIT_GLYPHS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };
    localparam logic [7:0] GLYPH_B = 8'h7C;
    localparam logic [7:0] GLYPH_R = 8'h50;

    // index 0 is the leftmost digit
    typedef logic [3:0][7:0] digits_t;

    typedef struct packed {
        digits_t    digits;
        logic [3:0] level;
        logic       range_error;
    } frame_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [13:0] s_number_in = '0;
    logic        s_blank_zeros = 1'b0;
    logic [1:0]  s_digit_position = '0;
    logic        s_point_on = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_seg_digit0;
    logic [7:0]  m_seg_digit1;
    logic [7:0]  m_seg_digit2;
    logic [7:0]  m_seg_digit3;
    logic [3:0]  m_level_out;
    logic        m_range_error;

    // predicted display state
    digits_t shown_digits = '0;
    logic [3:0] shown_level = '0;
    frame_t expected_frames [$];

    int error_count = 0;
    int idle_cycles = 0;
    bit src_idle_en = 1'b0;
    bit sink_idle_en = 1'b0;
    int hold_cycles = 0;

    seven_segment_frame_builder u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_number_in          (s_number_in),
        .s_blank_zeros        (s_blank_zeros),
        .s_digit_position     (s_digit_position),
        .s_point_on           (s_point_on),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_seg_digit0         (m_seg_digit0),
        .m_seg_digit1         (m_seg_digit1),
        .m_seg_digit2         (m_seg_digit2),
        .m_seg_digit3         (m_seg_digit3),
        .m_level_out          (m_level_out),
        .m_range_error        (m_range_error)
    );

    always #4 aclk = ~aclk;

    // decimal split through the font, rightmost digit always lit
    function automatic digits_t render_decimal(input int unsigned value, input logic omit);
        int unsigned d [4];
        digits_t r;
        d[0] = (value / 1000) % 10;
        d[1] = (value / 100) % 10;
        d[2] = (value / 10) % 10;
        d[3] = value % 10;
        r[0] = (!omit || d[0] != 0) ? DIGIT_GLYPHS[d[0]] : 8'h00;
        r[1] = (!omit || (d[0] | d[1]) != 0) ? DIGIT_GLYPHS[d[1]] : 8'h00;
        r[2] = (!omit || (d[0] | d[1] | d[2]) != 0) ? DIGIT_GLYPHS[d[2]] : 8'h00;
        r[3] = DIGIT_GLYPHS[d[3]];
        return r;
    endfunction

    // update the predicted display for one command word and queue its frame
    function automatic void apply_command(input ssfb_pkg::op_t op, input logic [13:0] num,
                                          input logic omit, input logic [1:0] pos,
                                          input logic on);
        frame_t f;
        f.range_error = 1'b0;
        case (op)
            ssfb_pkg::OP_SHOW: begin
                if (num > ssfb_pkg::MAX_NUMBER) begin
                    f.range_error = 1'b1;
                end else begin
                    shown_digits = render_decimal(32'(num), omit);
                end
            end
            ssfb_pkg::OP_POINT: begin
                shown_digits[pos][7] = on;
            end
            ssfb_pkg::OP_CLEAR: begin
                shown_digits = '0;
            end
            ssfb_pkg::OP_BRIGHT: begin
                if (num > ssfb_pkg::MAX_LEVEL) begin
                    f.range_error = 1'b1;
                end else begin
                    shown_level = num[3:0];
                    shown_digits = render_decimal(32'(num), 1'b1);
                    shown_digits[0] = GLYPH_B;
                    shown_digits[1] = GLYPH_R;
                end
            end
            default: begin
                f.range_error = 1'b0;
            end
        endcase
        f.digits = shown_digits;
        f.level = shown_level;
        expected_frames.push_back(f);
    endfunction

    // predict on accepted command words, compare accepted result words
    always @(posedge aclk) begin : scoreboard
        frame_t want;
        digits_t got;
        if (aresetn && s_valid && s_ready) begin
            apply_command(ssfb_pkg::op_t'(s_operation), s_number_in, s_blank_zeros,
                          s_digit_position, s_point_on);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_frames.size() == 0) begin
                $error("result word with no command pending");
                error_count++;
            end else begin
                want = expected_frames.pop_front();
                got = {m_seg_digit3, m_seg_digit2, m_seg_digit1, m_seg_digit0};
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want.digits[i]) begin
                        $error("seg_digit%0d: expected %h, got %h", i, want.digits[i], got[i]);
                        error_count++;
                    end
                end
                if (m_level_out !== want.level) begin
                    $error("level_out: expected %0d, got %0d", want.level, m_level_out);
                    error_count++;
                end
                if (m_range_error !== want.range_error) begin
                    $error("range_error: expected %b, got %b", want.range_error, m_range_error);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("seven_segment_frame_builder verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall bursts and the long hold-off
    initial begin : sink_side
        int burst;
        forever begin
            if (hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (sink_idle_en && $urandom_range(5, 0) == 0) begin
                burst = $urandom_range(13, 1);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // offer one command word and wait for its handshake; valid stays high after
    task automatic issue_command(input ssfb_pkg::op_t op, input logic [13:0] num,
                                 input logic omit, input logic [1:0] pos, input logic on);
        int gap;
        if (src_idle_en && $urandom_range(3, 0) == 0) begin
            gap = $urandom_range(13, 1);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_number_in <= num;
        s_blank_zeros <= omit;
        s_digit_position <= pos;
        s_point_on <= on;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // number field shaped for the chosen command
    function automatic logic [13:0] pick_number(input ssfb_pkg::op_t op);
        logic [13:0] n;
        case (op)
            ssfb_pkg::OP_SHOW: begin
                case ($urandom_range(9, 0))
                    0, 1:    n = 14'($urandom_range(9, 0));
                    2, 3:    n = 14'($urandom_range(999, 0));
                    4:       n = 14'($urandom_range(16383, 10000));
                    default: n = 14'($urandom_range(9999, 0));
                endcase
            end
            ssfb_pkg::OP_BRIGHT: begin
                case ($urandom_range(9, 0))
                    0:       n = 14'($urandom_range(31, 16));
                    1:       n = 14'($urandom_range(16383, 32));
                    default: n = 14'($urandom_range(15, 0));
                endcase
            end
            default: n = 14'($urandom_range(16383, 0));
        endcase
        return n;
    endfunction

    task automatic test_show_number();
        issue_command(ssfb_pkg::OP_SHOW, 14'd0, 1'b0, 2'd0, 1'b0);
        issue_command(ssfb_pkg::OP_SHOW, 14'd0, 1'b1, 2'd3, 1'b1);
        issue_command(ssfb_pkg::OP_SHOW, 14'd9999, 1'b1, 2'd3, 1'b1);
        issue_command(ssfb_pkg::OP_SHOW, 14'd1000, 1'b1, 2'd1, 1'b0);
        issue_command(ssfb_pkg::OP_SHOW, 14'd105, 1'b1, 2'd2, 1'b1);
        // out of range keeps the last frame
        issue_command(ssfb_pkg::OP_SHOW, 14'd10000, 1'b0, 2'd0, 1'b0);
        issue_command(ssfb_pkg::OP_SHOW, 14'd16383, 1'b1, 2'd3, 1'b1);
    endtask

    task automatic test_decimal_points();
        issue_command(ssfb_pkg::OP_SHOW, 14'd7, 1'b0, 2'd0, 1'b0);
        for (int i = 0; i < 4; i++) begin
            issue_command(ssfb_pkg::OP_POINT, 14'd16383, 1'b1, 2'(i), 1'b1);
        end
        issue_command(ssfb_pkg::OP_POINT, 14'd0, 1'b0, 2'd2, 1'b0);
        // showing a number drops every point
        issue_command(ssfb_pkg::OP_SHOW, 14'd8080, 1'b1, 2'd0, 1'b1);
    endtask

    task automatic test_clear();
        issue_command(ssfb_pkg::OP_CLEAR, 14'd16383, 1'b1, 2'd3, 1'b1);
        // point on a blank digit
        issue_command(ssfb_pkg::OP_POINT, 14'd0, 1'b0, 2'd0, 1'b1);
    endtask

    task automatic test_brightness();
        issue_command(ssfb_pkg::OP_BRIGHT, 14'd0, 1'b0, 2'd1, 1'b1);
        issue_command(ssfb_pkg::OP_BRIGHT, 14'd9, 1'b0, 2'd0, 1'b0);
        issue_command(ssfb_pkg::OP_BRIGHT, 14'd15, 1'b1, 2'd3, 1'b1);
        issue_command(ssfb_pkg::OP_BRIGHT, 14'd16, 1'b0, 2'd0, 1'b0);
        issue_command(ssfb_pkg::OP_BRIGHT, 14'd16383, 1'b1, 2'd2, 1'b0);
        issue_command(ssfb_pkg::OP_POINT, 14'd5, 1'b0, 2'd2, 1'b1);
        // clear keeps the level
        issue_command(ssfb_pkg::OP_CLEAR, 14'd0, 1'b0, 2'd0, 1'b0);
    endtask

    // receiver holds off while commands keep coming, so the input backs up
    task automatic test_pressure_stall();
        ssfb_pkg::op_t op;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_cycles = HOLD_OFF;
        for (int i = 0; i < 30; i++) begin
            op = ssfb_pkg::op_t'($urandom_range(3, 0));
            issue_command(op, pick_number(op), 1'($urandom), 2'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int count, input bit src_idle, input bit sink_idle);
        ssfb_pkg::op_t op;
        src_idle_en = src_idle;
        sink_idle_en = sink_idle;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3: op = ssfb_pkg::OP_SHOW;
                4, 5, 6:    op = ssfb_pkg::OP_POINT;
                7:          op = ssfb_pkg::OP_CLEAR;
                default:    op = ssfb_pkg::OP_BRIGHT;
            endcase
            issue_command(op, pick_number(op), 1'($urandom), 2'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        test_show_number();
        test_decimal_points();
        test_clear();
        test_brightness();

        test_random_traffic(220, 1'b1, 1'b1);
        test_pressure_stall();
        test_random_traffic(120, 1'b1, 1'b0);
        test_random_traffic(120, 1'b0, 1'b1);
        test_random_traffic(190, 1'b0, 1'b0);

        // drain, then allow the pipeline latency to settle
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0) begin
            $display("seven_segment_frame_builder verification clean");
        end else begin
            $display("seven_segment_frame_builder verification failed");
        end
        $finish;
    end

endmodule
